/* hdl/tcw_pkg.sv */
// Package: shared types, constants and codes of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int REQ_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int ROW_FLD_W  = 5;
    localparam int COL_FLD_W  = 7;
    localparam int COLOR_W    = 4;
    localparam int CELL_W     = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLOR_W;

    localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'h0A;
    localparam logic [COLOR_W-1:0] FG_RESET    = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET    = 4'h0;

    localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR = 1'b1;

    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_DRAIN,
        ST_BLANK,
        ST_PUT,
        ST_CLEAR
    } t_state;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_SCROLL,
        PTR_BLANK,
        PTR_CLEAR,
        PTR_STEP
    } t_ptr_op;

    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_READ_REQ,
        MEM_READ_PTR,
        MEM_WRITE_CUR,
        MEM_WRITE_PEND,
        MEM_WRITE_BLANK
    } t_mem_op;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_NEWLINE,
        CUR_HOME,
        CUR_PUT
    } t_cur_op;

    typedef enum logic {
        OUT_CURSOR,
        OUT_READ
    } t_out_sel;

    typedef struct packed {
        t_ptr_op  ptr_op;
        t_mem_op  mem_op;
        t_cur_op  cur_op;
        logic     latch;
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic newline;
        logic col_full;
        logic row_last;
        logic ptr_last;
        logic pend_char;
    } t_status;

endpackage

`default_nettype wire

/* hdl/text_console_writer_unit.sv */
// Top level: text console writer over a rows-by-columns screen memory.
//
// Input channel (i_in_valid / o_in_stall) takes one request word: put a
// character, clear the screen or read one cell. Output channel
// (o_out_valid / i_out_stall) returns one result word per request with the
// read cell (zero for other requests) and the cursor after the request.
// Configuration writes (i_cfg_we) set the foreground and background colors
// that form the attribute of every written cell.
// A clear blanks every cell. A put that scrolls moves every cell below
// the top row up a row, blanks the last row and then writes the
// character, if any. The screen memory has a single write port, so a
// clear or scroll takes no new request until every cell is moved or
// blanked. Ordinary puts sustain one word per cycle while the receiver
// does not stall.
// Reset puts the cursor at row 0, column 0, colors to white on black and
// empties the result register; screen contents stay undefined until the
// first clear. While the receiver stalls, the result word holds and the
// block takes no new request until the result is taken.
`default_nettype none

module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [REQ_W-1:0]      i_req_type,
    input  wire logic [CHAR_W-1:0]     i_char_code,
    input  wire logic [ROW_FLD_W-1:0]  i_read_row,
    input  wire logic [COL_FLD_W-1:0]  i_read_col,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [CHAR_W-1:0]          o_cell_char,
    output logic [ATTR_W-1:0]          o_cell_attr,
    output logic [ROW_FLD_W-1:0]       o_cursor_row,
    output logic [COL_FLD_W-1:0]       o_cursor_col
);

    t_cmd    cmd;
    t_status status;
    logic    ready;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_ready    (ready),
        .o_cmd      (cmd)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_out_stall  (i_out_stall),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

    assign o_in_stall = !ready;

endmodule

`default_nettype wire

/* hdl/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hdl/tcw_ctrl.sv */
// Controller: request sequencing for put, scroll, clear and read.
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [REQ_W-1:0] i_req_type,
    input  wire t_status          i_status,
    output logic                  o_ready,
    output t_cmd                  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '{ptr_op: PTR_HOLD, mem_op: MEM_NONE, cur_op: CUR_HOLD,
                    latch: 1'b0, out_load: 1'b0, out_sel: OUT_CURSOR};
        o_ready = (r_state == ST_IDLE) && i_status.out_free;
        unique case (r_state)
            ST_IDLE: begin
                if (o_ready && i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    unique case (i_req_type)
                        REQ_PUT: begin
                            if (i_status.newline) begin
                                if (i_status.row_last) begin
                                    o_cmd.cur_op = CUR_HOME;
                                    o_cmd.ptr_op = PTR_SCROLL;
                                    n_state      = ST_SCROLL;
                                end else begin
                                    o_cmd.cur_op   = CUR_NEWLINE;
                                    o_cmd.out_load = 1'b1;
                                end
                            end else if (i_status.col_full && i_status.row_last) begin
                                o_cmd.cur_op = CUR_HOME;
                                o_cmd.ptr_op = PTR_SCROLL;
                                n_state      = ST_SCROLL;
                            end else begin
                                o_cmd.mem_op   = MEM_WRITE_CUR;
                                o_cmd.cur_op   = CUR_PUT;
                                o_cmd.out_load = 1'b1;
                            end
                        end
                        REQ_CLEAR: begin
                            o_cmd.ptr_op = PTR_CLEAR;
                            n_state      = ST_CLEAR;
                        end
                        REQ_READ: begin
                            o_cmd.mem_op = MEM_READ_REQ;
                            n_state      = ST_READ;
                        end
                        default: begin
                            o_cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_sel  = OUT_READ;
                n_state        = ST_IDLE;
            end
            ST_SCROLL: begin
                o_cmd.mem_op = MEM_READ_PTR;
                o_cmd.ptr_op = PTR_STEP;
                if (i_status.ptr_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_cmd.ptr_op = PTR_BLANK;
                n_state      = ST_BLANK;
            end
            ST_BLANK: begin
                o_cmd.mem_op = MEM_WRITE_BLANK;
                o_cmd.ptr_op = PTR_STEP;
                if (i_status.ptr_last) begin
                    if (i_status.pend_char) begin
                        n_state = ST_PUT;
                    end else begin
                        o_cmd.out_load = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end
            end
            ST_PUT: begin
                o_cmd.mem_op   = MEM_WRITE_PEND;
                o_cmd.cur_op   = CUR_PUT;
                o_cmd.out_load = 1'b1;
                n_state        = ST_IDLE;
            end
            ST_CLEAR: begin
                o_cmd.mem_op = MEM_WRITE_BLANK;
                o_cmd.ptr_op = PTR_STEP;
                if (i_status.ptr_last) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/tcw_dp.sv */
// Datapath: cursor, colors, cell pointer, screen memory and result register.
`default_nettype none

module tcw_dp
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [CHAR_W-1:0]     i_char_code,
    input  wire logic [ROW_FLD_W-1:0]  i_read_row,
    input  wire logic [COL_FLD_W-1:0]  i_read_col,
    input  wire logic                  i_out_stall,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    output logic                       o_out_valid,
    output logic [CHAR_W-1:0]          o_cell_char,
    output logic [ATTR_W-1:0]          o_cell_attr,
    output logic [ROW_FLD_W-1:0]       o_cursor_row,
    output logic [COL_FLD_W-1:0]       o_cursor_col
);

    localparam int CELLS   = ROWS * COLUMNS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLUMNS + 1);

    logic [COLOR_W-1:0] r_fg;
    logic [COLOR_W-1:0] r_bg;
    logic [ROW_W-1:0]   r_row;
    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   r_col;
    logic [COL_W-1:0]   n_col;
    logic [CELL_AW-1:0] r_ptr;
    logic [CELL_AW-1:0] r_mv_addr;
    logic               r_mv_pend;
    logic [CHAR_W-1:0]  r_char;
    logic               r_pend_char;
    logic               r_rd_ok;
    logic               r_out_valid;
    logic [CELL_W-1:0]  r_out_cell;
    logic [ROW_W-1:0]   r_out_row;
    logic [COL_W-1:0]   r_out_col;

    logic [ATTR_W-1:0]  attr;
    logic               col_full;
    logic [ROW_W-1:0]   eff_row;
    logic [COL_W-1:0]   eff_col;
    logic [CELL_AW-1:0] cur_addr;
    logic [CELL_AW-1:0] req_addr;
    logic               req_ok;
    logic               ram_we;
    logic [CELL_AW-1:0] ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [CELL_AW-1:0] ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    assign attr     = {r_bg, r_fg};
    assign col_full = (r_col == COL_W'(COLUMNS));
    assign eff_row  = col_full ? ROW_W'(r_row + 1'b1) : r_row;
    assign eff_col  = col_full ? '0 : r_col;
    assign cur_addr = CELL_AW'(32'(eff_row) * 32'(COLUMNS) + 32'(eff_col));
    assign req_addr = CELL_AW'(32'(i_read_row) * 32'(COLUMNS) + 32'(i_read_col));
    assign req_ok   = (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLUMNS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FG_COLOR: r_fg <= i_cfg_data;
                REG_BG_COLOR: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        unique case (i_cmd.cur_op)
            CUR_HOLD: ;
            CUR_NEWLINE: begin
                n_row = ROW_W'(r_row + 1'b1);
                n_col = '0;
            end
            CUR_HOME: begin
                n_col = '0;
            end
            CUR_PUT: begin
                n_row = eff_row;
                n_col = COL_W'(eff_col + 1'b1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.ptr_op)
            PTR_HOLD:   ;
            PTR_SCROLL: r_ptr <= CELL_AW'(COLUMNS);
            PTR_BLANK:  r_ptr <= CELL_AW'(CELLS - COLUMNS);
            PTR_CLEAR:  r_ptr <= '0;
            PTR_STEP:   r_ptr <= CELL_AW'(r_ptr + 1'b1);
            default:    ;
        endcase
        r_mv_addr <= CELL_AW'(r_ptr - CELL_AW'(COLUMNS));
        if (i_cmd.latch) begin
            r_char      <= i_char_code;
            r_pend_char <= (i_char_code != CH_NEWLINE);
            r_rd_ok     <= req_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv_pend <= 1'b0;
        end else begin
            r_mv_pend <= (i_cmd.mem_op == MEM_READ_PTR);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = {attr, i_char_code};
        ram_re    = 1'b0;
        ram_raddr = r_ptr;
        if (r_mv_pend) begin
            ram_we    = 1'b1;
            ram_waddr = r_mv_addr;
            ram_wdata = ram_rdata;
        end
        unique case (i_cmd.mem_op)
            MEM_NONE: ;
            MEM_READ_REQ: begin
                ram_re    = req_ok;
                ram_raddr = req_addr;
            end
            MEM_READ_PTR: begin
                ram_re = 1'b1;
            end
            MEM_WRITE_CUR: begin
                ram_we = 1'b1;
            end
            MEM_WRITE_PEND: begin
                ram_we    = 1'b1;
                ram_wdata = {attr, r_char};
            end
            MEM_WRITE_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                ram_wdata = {attr, CH_SPACE};
            end
            default: ;
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_row  <= n_row;
            r_out_col  <= n_col;
            r_out_cell <= ((i_cmd.out_sel == OUT_READ) && r_rd_ok) ? ram_rdata : '0;
        end
    end

    assign o_status = '{out_free:  !r_out_valid || !i_out_stall,
                        newline:   (i_char_code == CH_NEWLINE),
                        col_full:  col_full,
                        row_last:  (r_row == ROW_W'(ROWS - 1)),
                        ptr_last:  (r_ptr == CELL_AW'(CELLS - 1)),
                        pend_char: r_pend_char};

    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_out_cell[CHAR_W-1:0];
    assign o_cell_attr  = r_out_cell[CELL_W-1:CHAR_W];
    assign o_cursor_row = ROW_FLD_W'(r_out_row);
    assign o_cursor_col = COL_FLD_W'(r_out_col);

endmodule

`default_nettype wire

/* hdl/tcw_checker.sv */
// Checker: port-level assertions for the text console writer, bound to the top.
`default_nettype none

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_cfg_we,
    input wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic [REQ_W-1:0]      i_req_type,
    input wire logic [CHAR_W-1:0]     i_char_code,
    input wire logic [ROW_FLD_W-1:0]  i_read_row,
    input wire logic [COL_FLD_W-1:0]  i_read_col,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic [CHAR_W-1:0]     o_cell_char,
    input wire logic [ATTR_W-1:0]     o_cell_attr,
    input wire logic [ROW_FLD_W-1:0]  o_cursor_row,
    input wire logic [COL_FLD_W-1:0]  o_cursor_col
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cell_char)
            && $stable(o_cell_attr) && $stable(o_cursor_row) && $stable(o_cursor_col))
        else $error("stalled result changed");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> o_in_stall)
        else $error("request taken while result blocked");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_cursor_col) <= COLUMNS) && (32'(o_cursor_row) < ROWS))
        else $error("cursor out of range");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (.*);

`default_nettype wire

/* verif/text_console_writer_unit_test.sv */
// Testbench for text_console_writer_unit: directed table, then random request streams.
module text_console_writer_unit_test;
    import tcw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS_N         = DEF_ROWS;
    localparam int COLS_N         = DEF_COLUMNS;
    localparam int CELLS          = ROWS_N * COLS_N;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = CELLS + 16;
    localparam int PHASE_WORDS    = 200;
    localparam int N_DIRECTED     = 23;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]     req;
        logic [CHAR_W-1:0]    ch;
        logic [ROW_FLD_W-1:0] row;
        logic [COL_FLD_W-1:0] col;
    } t_req_word;

    typedef struct packed {
        logic [CHAR_W-1:0]    cell_char;
        logic [ATTR_W-1:0]    cell_attr;
        logic [ROW_FLD_W-1:0] cursor_row;
        logic [COL_FLD_W-1:0] cursor_col;
    } t_cell_result;

    typedef struct packed {
        t_req_word    word;
        logic         typed;
        t_cell_result exp;
    } t_dir_row;

    localparam t_dir_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{'{REQ_PUT,    8'h41, 5'd0,  7'd0},   1'b1, '{8'h00, 8'h00, 5'd0, 7'd1}},
        '{'{REQ_UNUSED, 8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd1}},
        '{'{REQ_CLEAR,  8'h00, 5'd0,  7'd0},   1'b1, '{8'h00, 8'h00, 5'd0, 7'd1}},
        '{'{REQ_READ,   8'h00, 5'd0,  7'd0},   1'b1, '{8'h20, 8'h0F, 5'd0, 7'd1}},
        '{'{REQ_READ,   8'hFF, 5'd24, 7'd79},  1'b1, '{8'h20, 8'h0F, 5'd0, 7'd1}},
        '{'{REQ_READ,   8'h00, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd1}},
        '{'{REQ_READ,   8'h00, 5'd0,  7'd80},  1'b1, '{8'h00, 8'h00, 5'd0, 7'd1}},
        '{'{REQ_READ,   8'h00, 5'd25, 7'd0},   1'b1, '{8'h00, 8'h00, 5'd0, 7'd1}},
        '{'{REQ_PUT,    8'hFF, 5'd0,  7'd0},   1'b0, '0},
        '{'{REQ_PUT,    8'h00, 5'd0,  7'd0},   1'b0, '0},
        '{'{REQ_PUT,    8'h0A, 5'd0,  7'd0},   1'b0, '0},
        '{'{REQ_PUT,    8'h0A, 5'd31, 7'd127}, 1'b0, '0},
        '{'{REQ_READ,   8'h00, 5'd0,  7'd0},   1'b0, '0},
        '{'{REQ_READ,   8'h00, 5'd0,  7'd1},   1'b0, '0},
        '{'{REQ_READ,   8'h00, 5'd0,  7'd2},   1'b0, '0},
        '{'{REQ_PUT,    8'h7E, 5'd31, 7'd127}, 1'b0, '0},
        '{'{REQ_CLEAR,  8'hFF, 5'd31, 7'd127}, 1'b0, '0},
        '{'{REQ_READ,   8'h00, 5'd0,  7'd1},   1'b0, '0},
        '{'{REQ_UNUSED, 8'h00, 5'd0,  7'd0},   1'b0, '0},
        '{'{REQ_PUT,    8'h55, 5'd0,  7'd0},   1'b0, '0},
        '{'{REQ_PUT,    8'hAA, 5'd0,  7'd0},   1'b0, '0},
        '{'{REQ_READ,   8'h00, 5'd2,  7'd0},   1'b0, '0},
        '{'{REQ_READ,   8'h00, 5'd2,  7'd1},   1'b0, '0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [REQ_W-1:0]      i_req_type;
    logic [CHAR_W-1:0]     i_char_code;
    logic [ROW_FLD_W-1:0]  i_read_row;
    logic [COL_FLD_W-1:0]  i_read_col;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CHAR_W-1:0]     o_cell_char;
    logic [ATTR_W-1:0]     o_cell_attr;
    logic [ROW_FLD_W-1:0]  o_cursor_row;
    logic [COL_FLD_W-1:0]  o_cursor_col;

    text_console_writer_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // console mirror
    bit [CELL_W-1:0]  screen_mirror [CELLS];
    int unsigned      mirror_row;
    int unsigned      mirror_col;
    logic [COLOR_W-1:0] fg_mirror;
    logic [COLOR_W-1:0] bg_mirror;

    t_cell_result pending_results [$];
    t_req_word    stim_q [$];
    int           err_count;
    int           quiet_cycles;
    int           sender_idle_pct;
    int           receiver_stall_pct;
    logic         drv_typed;
    t_cell_result drv_exp;

    function automatic logic [CELL_W-1:0] colored_cell(input logic [CHAR_W-1:0] ch);
        return {bg_mirror, fg_mirror, ch};
    endfunction

    task automatic advance_line();
        mirror_col = 0;
        if (mirror_row < ROWS_N - 1) begin
            mirror_row++;
        end else begin
            for (int i = 0; i < CELLS - COLS_N; i++)
                screen_mirror[i] = screen_mirror[i + COLS_N];
            for (int c = 0; c < COLS_N; c++)
                screen_mirror[CELLS - COLS_N + c] = colored_cell(CH_SPACE);
        end
    endtask

    task automatic apply_request(input t_req_word w, output t_cell_result r);
        logic [CELL_W-1:0] rd_cell;
        rd_cell = '0;
        case (w.req)
            REQ_PUT: begin
                if (w.ch == CH_NEWLINE) begin
                    advance_line();
                end else begin
                    if (mirror_col >= COLS_N)
                        advance_line();
                    screen_mirror[mirror_row * COLS_N + mirror_col] = colored_cell(w.ch);
                    mirror_col++;
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_mirror[i] = colored_cell(CH_SPACE);
            end
            REQ_READ: begin
                if (w.row < ROWS_N && w.col < COLS_N)
                    rd_cell = screen_mirror[w.row * COLS_N + w.col];
            end
            default: ;
        endcase
        r.cell_char  = rd_cell[CHAR_W-1:0];
        r.cell_attr  = rd_cell[CELL_W-1:CHAR_W];
        r.cursor_row = ROW_FLD_W'(mirror_row);
        r.cursor_col = COL_FLD_W'(mirror_col);
    endtask

    task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
        if (exp != act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_cell_result predicted;
        t_cell_result exp;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FG_COLOR: fg_mirror = i_cfg_data;
                    REG_BG_COLOR: bg_mirror = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                apply_request('{i_req_type, i_char_code, i_read_row, i_read_col}, predicted);
                pending_results.push_back(drv_typed ? drv_exp : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no pending expectation");
                    err_count++;
                end else begin
                    exp = pending_results.pop_front();
                    check_field("cell_char", exp.cell_char, o_cell_char);
                    check_field("cell_attr", exp.cell_attr, o_cell_attr);
                    check_field("cursor_row", exp.cursor_row, o_cursor_row);
                    check_field("cursor_col", exp.cursor_col, o_cursor_col);
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_word(input t_req_word w, input logic typed, input t_cell_result exp);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= w.req;
        i_char_code <= w.ch;
        i_read_row  <= w.row;
        i_read_col  <= w.col;
        drv_typed = typed;
        drv_exp   = exp;
        do
            @(posedge i_clk);
        while (o_in_stall);
    endtask

    task automatic write_colors(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        @(negedge i_clk);
        i_in_valid  <= 1'b0;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_FG_COLOR;
        i_cfg_data  <= fg;
        @(negedge i_clk);
        i_cfg_index <= REG_BG_COLOR;
        i_cfg_data  <= bg;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_req_word random_word(input logic [REQ_W-1:0] req);
        t_req_word w;
        w.req = req;
        w.ch  = CHAR_W'($urandom_range(255));
        w.row = ROW_FLD_W'($urandom_range(31));
        w.col = COL_FLD_W'($urandom_range(127));
        return w;
    endfunction

    task automatic queue_sequence();
        int unsigned kind;
        int unsigned sel;
        int unsigned len;
        t_req_word   w;
        kind = $urandom_range(99);
        if (kind < 55) begin
            sel = $urandom_range(9);
            if (sel < 7)
                len = $urandom_range(40);
            else if (sel < 9)
                len = $urandom_range(84, 76);
            else
                len = $urandom_range(170, 150);
            repeat (len) begin
                w = random_word(REQ_PUT);
                while (w.ch == CH_NEWLINE)
                    w.ch = CHAR_W'($urandom_range(255));
                stim_q.push_back(w);
            end
            if ($urandom_range(9) < 7) begin
                w = random_word(REQ_PUT);
                w.ch = CH_NEWLINE;
                stim_q.push_back(w);
            end
        end else if (kind < 67) begin
            repeat ($urandom_range(24, 1)) begin
                w = random_word(REQ_PUT);
                w.ch = CH_NEWLINE;
                stim_q.push_back(w);
            end
        end else if (kind < 90) begin
            repeat ($urandom_range(4, 1)) begin
                w = random_word(REQ_READ);
                if ($urandom_range(9) == 0) begin
                    w.row = $urandom_range(1) ? ROW_FLD_W'(ROWS_N - 1) : '0;
                    w.col = $urandom_range(1) ? COL_FLD_W'(COLS_N - 1) : '0;
                end else begin
                    w.row = ROW_FLD_W'($urandom_range(ROWS_N - 1));
                    w.col = COL_FLD_W'($urandom_range(COLS_N - 1));
                end
                stim_q.push_back(w);
            end
        end else if (kind < 93) begin
            stim_q.push_back(random_word(REQ_CLEAR));
        end else begin
            if ($urandom_range(1)) begin
                w = random_word(REQ_UNUSED);
            end else begin
                w = random_word(REQ_READ);
                if ($urandom_range(1))
                    w.row = ROW_FLD_W'($urandom_range(31, ROWS_N));
                else
                    w.col = COL_FLD_W'($urandom_range(127, COLS_N));
            end
            stim_q.push_back(w);
        end
    endtask

    initial begin
        int        sent;
        t_req_word w;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        i_in_valid         = 1'b0;
        i_req_type         = '0;
        i_char_code        = '0;
        i_read_row         = '0;
        i_read_col         = '0;
        i_out_stall        = 1'b0;
        err_count          = 0;
        quiet_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        drv_typed          = 1'b0;
        drv_exp            = '0;
        mirror_row         = 0;
        mirror_col         = 0;
        fg_mirror          = FG_RESET;
        bg_mirror          = BG_RESET;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_word(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_colors('0, '0);
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    write_colors('1, '1);
                    sender_idle_pct    = 87;
                    receiver_stall_pct = 0;
                end
                2: begin
                    write_colors(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)));
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 87;
                end
                default: begin
                    write_colors(COLOR_W'($urandom_range(15)), COLOR_W'($urandom_range(15)));
                    sender_idle_pct    = 15;
                    receiver_stall_pct = 15;
                end
            endcase
            sent = 0;
            while (sent < PHASE_WORDS) begin
                if (stim_q.size() == 0)
                    queue_sequence();
                w = stim_q.pop_front();
                send_word(w, 1'b0, '0);
                if (w.req != REQ_UNUSED)
                    sent++;
            end
            wait_drained();
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
